### hdl/dq_pkg.sv
`default_nettype none

package dq_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_DUMP       = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic    push_back;
		logic    push_front;
		logic    pop_front;
		logic    pop_back;
		logic    dump_start;
		logic    dump_step;
		logic    load_out;
		logic    use_rdata;
		status_t st;
		logic    last;
	} dq_ctrl_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic empty;
		logic full;
		logic dump_final;
	} dq_stat_t;

endpackage

`default_nettype wire

### hdl/dq_in_if.sv
`default_nettype none

interface dq_in_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic [2:0]                   cmd;
	logic signed [DATA_WIDTH-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

### hdl/dq_out_if.sv
`default_nettype none

interface dq_out_if #(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 5
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] value_out;
	dq_pkg::status_t              status;
	logic [CNT_W-1:0]             entry_count;
	logic                         last;

	modport source (output valid, output value_out, output status, output entry_count,
		output last, input ready);
	modport sink (input valid, input value_out, input status, input entry_count,
		input last, output ready);
endinterface

`default_nettype wire

### hdl/dq_ram.sv
`default_nettype none

module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/dq_ctrl.sv
`default_nettype none

module dq_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	input  wire logic [2:0]       req_cmd,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	input  wire dq_pkg::dq_stat_t stat,
	output dq_pkg::dq_ctrl_t      ctl
);
	import dq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_DUMP
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == S_IDLE) && out_free;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		ctl = '0;
		ctl.st = ST_OK;
		case (state_q)
			S_IDLE: begin
				ctl.last = 1'b1;
				if (accept) begin
					case (req_cmd)
						CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
							ctl.load_out = 1'b1;
							if (stat.full) begin
								ctl.st = ST_FULL;
							end else begin
								ctl.push_back  = (req_cmd == CMD_PUSH_BACK);
								ctl.push_front = (req_cmd == CMD_PUSH_FRONT);
							end
						end
						CMD_POP_FRONT, CMD_POP_BACK: begin
							if (stat.empty) begin
								ctl.load_out = 1'b1;
								ctl.st = ST_EMPTY;
							end else begin
								ctl.pop_front = (req_cmd == CMD_POP_FRONT);
								ctl.pop_back  = (req_cmd == CMD_POP_BACK);
							end
						end
						CMD_DUMP: begin
							if (stat.empty) begin
								ctl.load_out = 1'b1;
								ctl.st = ST_EMPTY;
							end else begin
								ctl.dump_start = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_POP: begin
				// the output register is always free here
				ctl.load_out  = 1'b1;
				ctl.use_rdata = 1'b1;
				ctl.last      = 1'b1;
			end
			S_DUMP: begin
				if (out_free) begin
					ctl.load_out  = 1'b1;
					ctl.use_rdata = 1'b1;
					ctl.last      = stat.dump_final;
					ctl.dump_step = !stat.dump_final;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (ctl.pop_front || ctl.pop_back) begin
						state_q <= S_POP;
					end else if (ctl.dump_start) begin
						state_q <= S_DUMP;
					end
				end
				S_POP: begin
					state_q <= S_IDLE;
				end
				S_DUMP: begin
					if (ctl.load_out && stat.dump_final) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/dq_dp.sv
`default_nettype none

module dq_dp #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	parameter int AW         = $clog2(DEPTH),
	parameter int CW         = $clog2(DEPTH + 1)
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire dq_pkg::dq_ctrl_t             ctl,
	output dq_pkg::dq_stat_t                  stat,
	input  wire logic signed [DATA_WIDTH-1:0] req_value,
	output logic signed [DATA_WIDTH-1:0]      rsp_value_out,
	output dq_pkg::status_t                   rsp_status,
	output logic [CW-1:0]                     rsp_entry_count,
	output logic                              rsp_last
);
	import dq_pkg::*;

	function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] i);
		wrap_inc = (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] i);
		wrap_dec = (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
	endfunction

	logic [AW-1:0]         front_q, back_q, ptr_q;
	logic [CW-1:0]         count_q, remain_q, count_d;
	logic                  we, re;
	logic [AW-1:0]         waddr, raddr;
	logic [DATA_WIDTH-1:0] rdata;

	always_comb begin
		we    = ctl.push_back || ctl.push_front;
		waddr = ctl.push_front ? wrap_dec(front_q) : back_q;
		re    = ctl.pop_front || ctl.pop_back || ctl.dump_start || ctl.dump_step;
		if (ctl.pop_back) begin
			raddr = wrap_dec(back_q);
		end else if (ctl.dump_step) begin
			raddr = ptr_q;
		end else begin
			raddr = front_q;
		end
		if (we) begin
			count_d = count_q + 1'b1;
		end else if (ctl.pop_front || ctl.pop_back) begin
			count_d = count_q - 1'b1;
		end else begin
			count_d = count_q;
		end
	end

	assign stat.empty      = (count_q == '0);
	assign stat.full       = (count_q == CW'(DEPTH));
	assign stat.dump_final = (remain_q == CW'(1));

	dq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (req_value),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			back_q   <= '0;
			count_q  <= '0;
			ptr_q    <= '0;
			remain_q <= '0;
		end else begin
			count_q <= count_d;
			if (ctl.push_back) begin
				back_q <= wrap_inc(back_q);
			end
			if (ctl.push_front) begin
				front_q <= wrap_dec(front_q);
			end
			if (ctl.pop_front) begin
				front_q <= wrap_inc(front_q);
			end
			if (ctl.pop_back) begin
				back_q <= wrap_dec(back_q);
			end
			// dump walks a private pointer, the queue itself stays put
			if (ctl.dump_start) begin
				ptr_q    <= wrap_inc(front_q);
				remain_q <= count_q;
			end else if (ctl.dump_step) begin
				ptr_q    <= wrap_inc(ptr_q);
				remain_q <= remain_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			rsp_value_out   <= ctl.use_rdata ? rdata : '0;
			rsp_status      <= ctl.st;
			rsp_entry_count <= count_d;
			rsp_last        <= ctl.last;
		end
	end

endmodule

`default_nettype wire

### hdl/double_ended_queue.sv
`default_nettype none
// channel  dir  payload                                  transaction
// req      in   cmd, value                               one command
// rsp      out  value_out, status, entry_count, last     one result
//
// push, full push and any empty result: loaded into the result register in the accept cycle
// pop: registered read of the ring ram on accept, then the result register is loaded in S_POP
// dump of n entries: one entry per cycle while rsp is drained
// reset clears indices, count and control; ring contents are not cleared
// a new command is taken only when the controller is idle and the result register is
// empty or being taken; rsp stalls hold the dump in place

module double_ended_queue #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dq_in_if.sink     req,
	dq_out_if.source  rsp
);
	import dq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	dq_ctrl_t ctl;
	dq_stat_t stat;

	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	dq_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH),
		.CW         (CW)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.stat            (stat),
		.req_value       (req.value),
		.rsp_value_out   (rsp.value_out),
		.rsp_status      (rsp.status),
		.rsp_entry_count (rsp.entry_count),
		.rsp_last        (rsp.last)
	);

endmodule

`default_nettype wire

### dv/double_ended_queue_tb.sv
`default_nettype none

module double_ended_queue_tb;
	import dq_pkg::*;

	localparam int DEPTH       = 16;
	localparam int DATA_WIDTH  = 32;
	localparam int CNT_W       = 5;
	localparam int RAND_ITEMS  = 64;     // per idling phase
	localparam int CYCLE_LIMIT = 300000;
	localparam int TAIL_CYCLES = 40;

	// command codes the block must ignore
	localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

	localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = 32'sh7fffffff;
	localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = 32'sh80000000;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] value_out;
		status_t                      status;
		logic [CNT_W-1:0]             entry_count;
		logic                         last;
	} deq_result_t;

	typedef struct packed {
		logic [2:0]                   cmd;
		logic signed [DATA_WIDTH-1:0] value;
		logic [4:0]                   reps;
		logic                         fixed;
		deq_result_t                  want;
	} stim_row_t;

	localparam int DIR_ROWS = 17;

	localparam deq_result_t NO_RES    = '{32'sd0, ST_OK, 5'd0, 1'b0};
	localparam deq_result_t EMPTY_RES = '{32'sd0, ST_EMPTY, 5'd0, 1'b1};
	localparam deq_result_t FULL_RES  = '{32'sd0, ST_FULL, 5'd16, 1'b1};

	stim_row_t dir_tab [DIR_ROWS] = '{
		'{CMD_POP_FRONT,  32'sd0,         5'd1,  1'b1, EMPTY_RES},
		'{CMD_POP_BACK,   32'sd0,         5'd1,  1'b1, EMPTY_RES},
		'{CMD_DUMP,       32'sd0,         5'd1,  1'b1, EMPTY_RES},
		'{CMD_UNUSED_LO,  32'sd0,         5'd1,  1'b0, NO_RES},
		'{CMD_UNUSED_HI,  -32'sd1,        5'd1,  1'b0, NO_RES},
		'{CMD_PUSH_BACK,  VAL_MAX,        5'd1,  1'b1, '{32'sd0, ST_OK, 5'd1, 1'b1}},
		'{CMD_PUSH_FRONT, VAL_MIN,        5'd1,  1'b1, '{32'sd0, ST_OK, 5'd2, 1'b1}},
		'{CMD_PUSH_BACK,  32'sd0,         5'd1,  1'b0, NO_RES},
		'{CMD_PUSH_FRONT, -32'sd1,        5'd1,  1'b0, NO_RES},
		'{CMD_DUMP,       32'sd0,         5'd1,  1'b0, NO_RES},
		'{CMD_POP_FRONT,  32'sd0,         5'd1,  1'b0, NO_RES},
		'{CMD_POP_BACK,   32'sd0,         5'd1,  1'b0, NO_RES},
		'{CMD_PUSH_BACK,  32'sh5a5a5a5a,  5'd14, 1'b0, NO_RES},
		'{CMD_PUSH_BACK,  32'sh12345678,  5'd1,  1'b1, FULL_RES},
		'{CMD_PUSH_FRONT, 32'sh12345678,  5'd1,  1'b1, FULL_RES},
		'{CMD_DUMP,       32'sd0,         5'd1,  1'b0, NO_RES},
		'{CMD_POP_BACK,   32'sd0,         5'd1,  1'b0, NO_RES}
	};

	logic clk = 1'b0;
	logic arst_n;

	dq_in_if  #(.DATA_WIDTH(DATA_WIDTH))                req_if ();
	dq_out_if #(.DATA_WIDTH(DATA_WIDTH), .CNT_W(CNT_W)) rsp_if ();

	double_ended_queue #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the deque
	logic signed [DATA_WIDTH-1:0] q_ring [DEPTH];
	int                           q_front = 0;
	int                           q_back  = 0;
	logic [CNT_W-1:0]             q_count = '0;

	deq_result_t step_res [$];
	deq_result_t pending_results [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int err_cnt        = 0;
	int cycle_cnt      = 0;

	task automatic predict_deque_op(input logic [2:0] cmd,
		input logic signed [DATA_WIDTH-1:0] value);
		int slot;
		step_res.delete();
		case (cmd)
			CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
				if (q_count == DEPTH) begin
					step_res.push_back('{32'sd0, ST_FULL, q_count, 1'b1});
				end else begin
					if (cmd == CMD_PUSH_BACK) begin
						q_ring[q_back] = value;
						q_back = (q_back + 1) % DEPTH;
					end else begin
						q_front = (q_front + DEPTH - 1) % DEPTH;
						q_ring[q_front] = value;
					end
					q_count = q_count + 1'b1;
					step_res.push_back('{32'sd0, ST_OK, q_count, 1'b1});
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (q_count == 0) begin
					step_res.push_back(EMPTY_RES);
				end else begin
					if (cmd == CMD_POP_FRONT) begin
						slot = q_front;
						q_front = (q_front + 1) % DEPTH;
					end else begin
						q_back = (q_back + DEPTH - 1) % DEPTH;
						slot = q_back;
					end
					q_count = q_count - 1'b1;
					step_res.push_back('{q_ring[slot], ST_OK, q_count, 1'b1});
				end
			end
			CMD_DUMP: begin
				if (q_count == 0) begin
					step_res.push_back(EMPTY_RES);
				end else begin
					slot = q_front;
					for (int k = 0; k < q_count; k++) begin
						step_res.push_back('{q_ring[slot], ST_OK, q_count, k == q_count - 1});
						slot = (slot + 1) % DEPTH;
					end
				end
			end
			default: ;
		endcase
	endtask

	// one command transaction; valid stays high across back-to-back transactions
	task automatic send_cmd(input logic [2:0] cmd, input logic signed [DATA_WIDTH-1:0] value,
		input logic use_fixed, input deq_result_t fixed_res);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.cmd   <= cmd;
		req_if.value <= value;
		do @(posedge clk); while (!req_if.ready);
		predict_deque_op(cmd, value);
		if (use_fixed)
			pending_results.push_back(fixed_res);
		else
			foreach (step_res[i]) pending_results.push_back(step_res[i]);
	endtask

	task automatic drain_results();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		rsp_if.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : rsp_check
		deq_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_results.size() == 0) begin
				if (err_cnt < 10)
					$display("unexpected result: value_out %0d status %0d count %0d last %0b",
						rsp_if.value_out, rsp_if.status, rsp_if.entry_count, rsp_if.last);
				err_cnt++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_if.value_out !== want.value_out || rsp_if.status !== want.status ||
					rsp_if.entry_count !== want.entry_count || rsp_if.last !== want.last) begin
					if (err_cnt < 10)
						$display("mismatch exp/act: val %0d/%0d st %0d/%0d cnt %0d/%0d last %0b/%0b",
							want.value_out, rsp_if.value_out, want.status, rsp_if.status,
							want.entry_count, rsp_if.entry_count, want.last, rsp_if.last);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int                           counted;
		int                           r;
		logic                         push_heavy;
		logic [2:0]                   c;
		logic signed [DATA_WIDTH-1:0] v;

		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.cmd   = CMD_PUSH_BACK;
		req_if.value = '0;
		push_heavy   = 1'b1;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct  = 32;
		recv_stall_pct = 83;
		for (int i = 0; i < DIR_ROWS; i++)
			for (int k = 0; k < dir_tab[i].reps; k++)
				send_cmd(dir_tab[i].cmd, dir_tab[i].value + k, dir_tab[i].fixed, dir_tab[i].want);
		drain_results();

		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 32;
					recv_stall_pct = 83;
				end
				1: begin
					send_idle_pct  = 83;
					recv_stall_pct = 32;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			counted = 0;
			while (counted < RAND_ITEMS) begin
				// swing between filling and emptying so both full and empty get hit
				if ($urandom_range(11) == 0)
					push_heavy = !push_heavy;
				r = $urandom_range(99);
				if (r < 6)
					c = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
				else if (r < 18)
					c = CMD_DUMP;
				else if ($urandom_range(99) < (push_heavy ? 75 : 25))
					c = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
				else
					c = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
				case ($urandom_range(15))
					0:       v = VAL_MAX;
					1:       v = VAL_MIN;
					2:       v = '0;
					3:       v = -32'sd1;
					default: v = $urandom;
				endcase
				send_cmd(c, v, 1'b0, NO_RES);
				if (c <= CMD_DUMP)
					counted++;
			end
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
hdl/dq_pkg.sv
hdl/dq_in_if.sv
hdl/dq_out_if.sv
hdl/dq_ram.sv
hdl/dq_ctrl.sv
hdl/dq_dp.sv
hdl/double_ended_queue.sv
dv/double_ended_queue_tb.sv
